// ===== rtl/pfe_pkg.sv =====
// Shared types, register indexes and helper functions of the path fitness evaluator.
package pfe_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_LON_MAX     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LON_MIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_MIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_MIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_SCALE = 3'd5;

  localparam logic [23:0] VALUE_SCALE_RESET = 24'd65536;

  localparam int STEPS  = 32;
  localparam int STEP_W = 5;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_SQRT,
    OP_DIV
  } pfe_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RMUL_X,
    ST_RMUL_Y,
    ST_RSUM,
    ST_RSQRT,
    ST_EMUL_X,
    ST_EMUL_Y,
    ST_ESUM,
    ST_ESQRT,
    ST_EDIV,
    ST_EDIVW,
    ST_EADD,
    ST_VMUL,
    ST_VADD,
    ST_DONE
  } pfe_state_t;

  typedef struct packed {
    logic [30:0]        rx;
    logic [30:0]        ry;
    logic signed [23:0] value_min;
    logic [23:0]        value_scale;
    logic               region_wr;
  } pfe_cfg_t;

  typedef struct packed {
    logic               start;
    pfe_op_t            op;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic [63:0]        sq_in;
    logic [31:0]        div_num;
    logic [31:0]        div_den;
  } pfe_cmd_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [65:0] product;
    logic [31:0]        root;
  } pfe_rsp_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] score;
    logic               saturated;
  } pfe_result_t;

  function automatic logic [30:0] absdiff_half(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [32:0] d;
    logic [32:0]        m;
    d = 33'(a) - 33'(b);
    m = d[32] ? 33'(-d) : 33'(d);
    return m[31:1];
  endfunction

endpackage

// ===== rtl/pfe_cfg.sv =====
// Configuration registers and derived region half-spans.
module pfe_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data,
  output pfe_pkg::pfe_cfg_t              cfg
);

  logic signed [31:0] lon_max;
  logic signed [31:0] lon_min;
  logic signed [31:0] lat_max;
  logic signed [31:0] lat_min;
  logic signed [23:0] value_min;
  logic [23:0]        value_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      lon_max     <= '0;
      lon_min     <= '0;
      lat_max     <= '0;
      lat_min     <= '0;
      value_min   <= '0;
      value_scale <= pfe_pkg::VALUE_SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfe_pkg::REG_LON_MAX:     lon_max     <= cfg_data;
        pfe_pkg::REG_LON_MIN:     lon_min     <= cfg_data;
        pfe_pkg::REG_LAT_MAX:     lat_max     <= cfg_data;
        pfe_pkg::REG_LAT_MIN:     lat_min     <= cfg_data;
        pfe_pkg::REG_VALUE_MIN:   value_min   <= cfg_data[23:0];
        pfe_pkg::REG_VALUE_SCALE: value_scale <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.rx          = pfe_pkg::absdiff_half(lon_max, lon_min);
    cfg.ry          = pfe_pkg::absdiff_half(lat_max, lat_min);
    cfg.value_min   = value_min;
    cfg.value_scale = value_scale;
    cfg.region_wr   = cfg_we && (cfg_index == pfe_pkg::REG_LON_MAX ||
                                 cfg_index == pfe_pkg::REG_LON_MIN ||
                                 cfg_index == pfe_pkg::REG_LAT_MAX ||
                                 cfg_index == pfe_pkg::REG_LAT_MIN);
  end

endmodule

// ===== rtl/pfe_unit.sv =====
// Shared arithmetic unit: one multiplier and one compare-subtract for root and divide.
module pfe_unit (
  input  logic              clk,
  input  logic              rst,
  input  pfe_pkg::pfe_cmd_t cmd,
  output pfe_pkg::pfe_rsp_t rsp
);

  logic                       running;
  logic                       done;
  logic [pfe_pkg::STEP_W-1:0] count;
  pfe_pkg::pfe_op_t           op_r;

  logic [63:0]        x;
  logic [63:0]        res;
  logic [63:0]        bitr;
  logic [31:0]        den_r;
  logic signed [65:0] product;

  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [65:0] mult;
  logic [63:0]        cs_a;
  logic [63:0]        cs_b;
  logic [63:0]        diff;
  logic               borrow;
  logic               geq;

  assign ma   = cmd.mul_a;
  assign mb   = cmd.mul_b;
  assign mult = ma * mb;

  always_comb begin
    cs_a = x;
    cs_b = res + bitr;
    if (op_r == pfe_pkg::OP_DIV) begin
      cs_a = {31'b0, x[31:0], bitr[31]};
      cs_b = {32'b0, den_r};
    end
    {borrow, diff} = {1'b0, cs_a} - {1'b0, cs_b};
    geq = !borrow;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
      op_r    <= pfe_pkg::OP_MUL;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        op_r <= cmd.op;
        if (cmd.op != pfe_pkg::OP_MUL) begin
          running <= 1'b1;
          count   <= pfe_pkg::STEP_W'(pfe_pkg::STEPS - 1);
        end
      end else if (running) begin
        count <= count - 1'b1;
        if (count == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      unique case (cmd.op)
        pfe_pkg::OP_MUL: product <= mult;
        pfe_pkg::OP_SQRT: begin
          x    <= cmd.sq_in;
          res  <= '0;
          bitr <= 64'h4000_0000_0000_0000;
        end
        pfe_pkg::OP_DIV: begin
          x     <= {48'b0, cmd.div_num[31:16]};
          res   <= '0;
          bitr  <= {32'b0, cmd.div_num[15:0], 16'b0};
          den_r <= cmd.div_den;
        end
        default: ;
      endcase
    end else if (running) begin
      if (op_r == pfe_pkg::OP_DIV) begin
        x    <= geq ? diff : cs_a;
        res  <= {res[62:0], geq};
        bitr <= bitr << 1;
      end else begin
        if (geq) begin
          x   <= diff;
          res <= (res >> 1) + bitr;
        end else begin
          res <= res >> 1;
        end
        bitr <= bitr >> 2;
      end
    end
  end

  always_comb begin
    rsp.busy    = running;
    rsp.done    = done;
    rsp.product = product;
    rsp.root    = res[31:0];
  end

endmodule

// ===== rtl/pfe_seq.sv =====
// Sequencer: walks each node through the shared unit and keeps the path score.
module pfe_seq #(
  parameter int MAX_PATH_NODES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   node_lat,
  input  logic signed [31:0]   node_lon,
  input  logic signed [23:0]   node_value,
  input  logic                 last_node,
  input  pfe_pkg::pfe_cfg_t    cfg,
  input  pfe_pkg::pfe_rsp_t    ursp,
  output pfe_pkg::pfe_cmd_t    ucmd,
  input  logic                 out_free,
  output pfe_pkg::pfe_result_t res
);

  localparam int CNT_W = $clog2(MAX_PATH_NODES + 1);

  pfe_pkg::pfe_state_t state;
  pfe_pkg::pfe_state_t state_next;

  logic               have_prev;
  logic               sat;
  logic signed [31:0] acc;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_inc;
  logic               dd_valid;

  logic signed [31:0] prev_lat;
  logic signed [31:0] prev_lon;
  logic [30:0]        dx;
  logic [30:0]        dy;
  logic signed [24:0] vdiff;
  logic               final_r;
  logic [62:0]        sq_sum;
  logic [31:0]        dd;
  logic [31:0]        quo;

  logic               accept;
  logic               clamp;
  logic signed [33:0] edge_term;
  logic signed [32:0] vterm;
  logic signed [33:0] add_term;
  logic [32:0]        add_out;

  function automatic logic [32:0] sat_add(input logic signed [31:0] a,
                                          input logic signed [33:0] t);
    logic signed [34:0] s;
    s = 35'(a) + 35'(t);
    if (s > 35'sh0_7FFF_FFFF) begin
      return {1'b1, 32'h7FFF_FFFF};
    end else if (s < -35'sh0_8000_0000) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, s[31:0]};
  endfunction

  assign accept    = in_valid && in_ready;
  assign count_inc = count + CNT_W'(1);
  assign clamp     = (dd == '0) || ({16'b0, ursp.root[31:16]} >= dd);
  assign edge_term = 34'sd65536 - $signed({2'b0, quo});
  assign vterm     = ursp.product[48:16];
  assign add_term  = (state == pfe_pkg::ST_EADD) ? edge_term : 34'(vterm);
  assign add_out   = sat_add(acc, add_term);

  always_comb begin
    state_next    = state;
    ucmd          = '0;
    ucmd.div_num  = ursp.root;
    ucmd.div_den  = dd;
    in_ready      = (state == pfe_pkg::ST_IDLE);
    res.valid     = (state == pfe_pkg::ST_DONE);
    res.score     = acc;
    res.saturated = sat;
    unique case (state)
      pfe_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (have_prev) begin
            state_next = dd_valid ? pfe_pkg::ST_EMUL_X : pfe_pkg::ST_RMUL_X;
          end else begin
            state_next = pfe_pkg::ST_VMUL;
          end
        end
      end
      pfe_pkg::ST_RMUL_X: begin
        ucmd.start = 1'b1;
        ucmd.op    = pfe_pkg::OP_MUL;
        ucmd.mul_a = {2'b0, cfg.rx};
        ucmd.mul_b = {2'b0, cfg.rx};
        state_next = pfe_pkg::ST_RMUL_Y;
      end
      pfe_pkg::ST_RMUL_Y: begin
        ucmd.start = 1'b1;
        ucmd.op    = pfe_pkg::OP_MUL;
        ucmd.mul_a = {2'b0, cfg.ry};
        ucmd.mul_b = {2'b0, cfg.ry};
        state_next = pfe_pkg::ST_RSUM;
      end
      pfe_pkg::ST_RSUM: begin
        ucmd.start = 1'b1;
        ucmd.op    = pfe_pkg::OP_SQRT;
        ucmd.sq_in = 64'(sq_sum) + 64'(ursp.product[61:0]);
        state_next = pfe_pkg::ST_RSQRT;
      end
      pfe_pkg::ST_RSQRT: begin
        if (ursp.done) begin
          state_next = pfe_pkg::ST_EMUL_X;
        end
      end
      pfe_pkg::ST_EMUL_X: begin
        ucmd.start = 1'b1;
        ucmd.op    = pfe_pkg::OP_MUL;
        ucmd.mul_a = {2'b0, dx};
        ucmd.mul_b = {2'b0, dx};
        state_next = pfe_pkg::ST_EMUL_Y;
      end
      pfe_pkg::ST_EMUL_Y: begin
        ucmd.start = 1'b1;
        ucmd.op    = pfe_pkg::OP_MUL;
        ucmd.mul_a = {2'b0, dy};
        ucmd.mul_b = {2'b0, dy};
        state_next = pfe_pkg::ST_ESUM;
      end
      pfe_pkg::ST_ESUM: begin
        ucmd.start = 1'b1;
        ucmd.op    = pfe_pkg::OP_SQRT;
        ucmd.sq_in = 64'(sq_sum) + 64'(ursp.product[61:0]);
        state_next = pfe_pkg::ST_ESQRT;
      end
      pfe_pkg::ST_ESQRT: begin
        if (ursp.done) begin
          state_next = pfe_pkg::ST_EDIV;
        end
      end
      pfe_pkg::ST_EDIV: begin
        if (clamp) begin
          state_next = pfe_pkg::ST_EADD;
        end else begin
          ucmd.start = 1'b1;
          ucmd.op    = pfe_pkg::OP_DIV;
          state_next = pfe_pkg::ST_EDIVW;
        end
      end
      pfe_pkg::ST_EDIVW: begin
        if (ursp.done) begin
          state_next = pfe_pkg::ST_EADD;
        end
      end
      pfe_pkg::ST_EADD: begin
        state_next = pfe_pkg::ST_VMUL;
      end
      pfe_pkg::ST_VMUL: begin
        ucmd.start = 1'b1;
        ucmd.op    = pfe_pkg::OP_MUL;
        ucmd.mul_a = 33'(vdiff);
        ucmd.mul_b = {9'b0, cfg.value_scale};
        state_next = pfe_pkg::ST_VADD;
      end
      pfe_pkg::ST_VADD: begin
        state_next = final_r ? pfe_pkg::ST_DONE : pfe_pkg::ST_IDLE;
      end
      pfe_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = pfe_pkg::ST_IDLE;
        end
      end
      default: state_next = pfe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pfe_pkg::ST_IDLE;
      have_prev <= 1'b0;
      sat       <= 1'b0;
      acc       <= '0;
      count     <= '0;
      dd_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.region_wr) begin
        dd_valid <= 1'b0;
      end else if (state == pfe_pkg::ST_RSQRT && ursp.done) begin
        dd_valid <= 1'b1;
      end
      if (accept) begin
        have_prev <= 1'b1;
        count     <= count_inc;
      end
      if (state == pfe_pkg::ST_EADD || state == pfe_pkg::ST_VADD) begin
        acc <= add_out[31:0];
        if (add_out[32]) begin
          sat <= 1'b1;
        end
      end
      if (state == pfe_pkg::ST_DONE && out_free) begin
        have_prev <= 1'b0;
        sat       <= 1'b0;
        acc       <= '0;
        count     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dx       <= pfe_pkg::absdiff_half(node_lon, prev_lon);
      dy       <= pfe_pkg::absdiff_half(node_lat, prev_lat);
      prev_lat <= node_lat;
      prev_lon <= node_lon;
      vdiff    <= 25'(node_value) - 25'(cfg.value_min);
      final_r  <= last_node || (count_inc == CNT_W'(MAX_PATH_NODES));
    end
    if (state == pfe_pkg::ST_RMUL_Y || state == pfe_pkg::ST_EMUL_Y) begin
      sq_sum <= 63'(ursp.product[61:0]);
    end
    if (state == pfe_pkg::ST_RSQRT && ursp.done) begin
      dd <= ursp.root;
    end
    if (state == pfe_pkg::ST_EDIV && clamp) begin
      quo <= '1;
    end
    if (state == pfe_pkg::ST_EDIVW && ursp.done) begin
      quo <= ursp.root;
    end
  end

endmodule

// ===== rtl/path_fitness_evaluator.sv =====
// Top level of the path fitness evaluator: configuration, sequencer, shared unit, result register.
//
// Nodes of a path arrive on the in_valid / in_ready channel, one transaction per node,
// with last_node marking the end of the path. Each path yields one transaction on the
// out_valid / out_ready channel carrying path_score (Q16.16, saturated) and
// score_saturated. A path longer than MAX_PATH_NODES closes at that node.
// The block works on one node at a time and drops in_ready while it does.
// The first node of a path adds only its value term (multiply, add). Every later node
// adds the edge term: two squares, a 32-step square root and a 32-step divide on the
// shared unit; the divide is skipped when the quotient saturates.
// After a write to any of the four region bounds, the next edge recomputes the
// region half-diagonal on the same unit.
// A closing node moves its score into the result register through the done state.
// The result register lets the next path start while a score waits; if the receiver
// still stalls when the next path closes, the block holds in_ready low until the
// older score is taken.
// Configuration registers are written through cfg_we / cfg_index / cfg_data and take
// effect at once; write them only while no path is in progress.
// Reset (rst, synchronous) restores register defaults and clears the path state.
module path_fitness_evaluator #(
  parameter int MAX_PATH_NODES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            node_lat,
  input  logic signed [31:0]            node_lon,
  input  logic signed [23:0]            node_value,
  input  logic                          last_node,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            path_score,
  output logic                          score_saturated
);

  pfe_pkg::pfe_cfg_t    cfg;
  pfe_pkg::pfe_cmd_t    ucmd;
  pfe_pkg::pfe_rsp_t    ursp;
  pfe_pkg::pfe_result_t res;
  logic                 out_free;

  assign out_free = !out_valid || out_ready;

  pfe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pfe_unit u_unit (
    .clk (clk),
    .rst (rst),
    .cmd (ucmd),
    .rsp (ursp)
  );

  pfe_seq #(
    .MAX_PATH_NODES (MAX_PATH_NODES)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .node_lat   (node_lat),
    .node_lon   (node_lon),
    .node_value (node_value),
    .last_node  (last_node),
    .cfg        (cfg),
    .ursp       (ursp),
    .ucmd       (ucmd),
    .out_free   (out_free),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && out_free) begin
      path_score      <= res.score;
      score_saturated <= res.saturated;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an accepted transaction");

  a_unit_free: assert property (@(posedge clk) disable iff (rst)
    ucmd.start |-> !ursp.busy)
    else $error("shared unit started while busy");

  a_result_loads: assert property (@(posedge clk) disable iff (rst)
    res.valid && !out_valid |=> out_valid)
    else $error("finished score not moved into the result register");
`endif

endmodule
